// ===== rtl/rau_pkg.sv =====
// rational arithmetic unit: shared types, codes and command/status structs
`default_nettype none
package rau_pkg;

  localparam int unsigned DW = 64;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_CMP  = 3'd4;
  localparam logic [2:0] OP_NORM = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_GCD,
    CMD_DIV,
    CMD_MUL,
    CMD_ADDSUB,
    CMD_SIGN,
    CMD_CMP,
    CMD_COPY,
    CMD_FINISH
  } dp_cmd_t;

  typedef enum logic [2:0] {
    R_LM, R_LD, R_RM, R_RD, R_PM, R_PD, R_T1, R_T2
  } reg_sel_t;

  typedef enum logic [1:0] {
    PR_L, PR_R, PR_P
  } pair_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK,
    S_RG, S_RGW, S_RX, S_RXW, S_RY, S_RYW,
    S_AG, S_AGW, S_AQ1, S_AQ1W, S_AQ2, S_AQ2W, S_AM1, S_AM2, S_AM3, S_AS,
    S_M1, S_M2, S_MS,
    S_CM1, S_CM2, S_CC,
    S_CP, S_FIN
  } ctrl_state_t;

  typedef struct packed {
    dp_cmd_t    cmd;
    reg_sel_t   sa;
    reg_sel_t   sb;
    reg_sel_t   dst;
    logic       sub;
    logic       cmp;
    logic [1:0] err;
  } dp_ctl_t;

  typedef struct packed {
    logic gcd_done;
    logic div_done;
    logic lden_zero;
    logic rden_zero;
    logic rm_zero;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/rational_arithmetic_unit_core.sv =====
// Rational arithmetic unit: add, subtract, multiply, divide, compare or normalize two
// signed fractions, every result reduced by gcd with the sign on the numerator. Pulse
// start while busy is low to issue a beat; busy then stays high until the result.
// A zero denominator is flagged right after the operands load; otherwise the run time
// depends on the operands. Normalize reduces the left operand only; add, subtract,
// multiply and divide reduce both operands and then the result, and compare reduces
// both operands only. Each reduction runs a binary gcd that takes one subtract or shift
// per cycle and two exact divisions on a restoring divider. Add and subtract spend
// one more gcd and two more divisions on the common denominator. The result beat is
// shown for exactly one cycle, marked by done, and cannot be held off: capture it when
// done is high.
`default_nettype none
module rational_arithmetic_unit_core #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         op,
  input  wire logic signed [31:0] left_num,
  input  wire logic signed [31:0] left_den,
  input  wire logic signed [31:0] right_num,
  input  wire logic signed [31:0] right_den,
  output logic                    done,
  output logic signed [31:0]      result_num,
  output logic [30:0]             result_den,
  output logic                    is_less,
  output logic                    is_greater,
  output logic                    is_equal,
  output logic [1:0]              status
);
  import rau_pkg::*;

  dp_ctl_t  ctl;
  dp_stat_t st;

  rau_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .st    (st),
    .ctl   (ctl),
    .busy  (busy)
  );

  rau_datapath #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .st         (st),
    .left_num   (left_num),
    .left_den   (left_den),
    .right_num  (right_num),
    .right_den  (right_den),
    .done       (done),
    .result_num (result_num),
    .result_den (result_den),
    .is_less    (is_less),
    .is_greater (is_greater),
    .is_equal   (is_equal),
    .status     (status)
  );

endmodule
`default_nettype wire

// ===== rtl/rau_gcd.sv =====
// binary gcd of two 64-bit magnitudes, one step per cycle
`default_nettype none
module rau_gcd (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [rau_pkg::DW-1:0] a,
  input  wire logic [rau_pkg::DW-1:0] b,
  output logic                       done,
  output logic [rau_pkg::DW-1:0]     g
);
  import rau_pkg::*;

  logic          run;
  logic [DW-1:0] x;
  logic [DW-1:0] y;
  logic [5:0]    k;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        x   <= a;
        y   <= b;
        k   <= '0;
      end else if (run) begin
        if (x == '0) begin
          g    <= y << k;
          run  <= 1'b0;
          done <= 1'b1;
        end else if (y == '0) begin
          g    <= x << k;
          run  <= 1'b0;
          done <= 1'b1;
        end else if (!x[0] && !y[0]) begin
          x <= x >> 1;
          y <= y >> 1;
          k <= k + 6'd1;
        end else if (!x[0]) begin
          x <= x >> 1;
        end else if (!y[0]) begin
          y <= y >> 1;
        end else if (x >= y) begin
          x <= x - y;
        end else begin
          y <= y - x;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rau_div.sv =====
// restoring 64-bit divider, one quotient bit per cycle
`default_nettype none
module rau_div (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [rau_pkg::DW-1:0] n,
  input  wire logic [rau_pkg::DW-1:0] d,
  output logic                       done,
  output logic [rau_pkg::DW-1:0]     q
);
  import rau_pkg::*;

  logic          run;
  logic [DW-1:0] r;
  logic [DW-1:0] dv;
  logic [5:0]    cnt;
  logic [DW:0]   rr;
  logic          fit;

  always_comb begin
    rr  = {r, q[DW-1]};
    fit = rr >= {1'b0, dv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        r   <= '0;
        q   <= n;
        dv  <= d;
        cnt <= '1;
      end else if (run) begin
        r   <= fit ? DW'(rr - {1'b0, dv}) : rr[DW-1:0];
        q   <= {q[DW-2:0], fit};
        cnt <= cnt - 6'd1;
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rau_datapath.sv =====
// operand registers, multiplier, add/sub, compare and result formatting
`default_nettype none
module rau_datapath #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire rau_pkg::dp_ctl_t   ctl,
  output rau_pkg::dp_stat_t       st,
  input  wire logic signed [31:0] left_num,
  input  wire logic signed [31:0] left_den,
  input  wire logic signed [31:0] right_num,
  input  wire logic signed [31:0] right_den,
  output logic                    done,
  output logic signed [31:0]      result_num,
  output logic [30:0]             result_den,
  output logic                    is_less,
  output logic                    is_greater,
  output logic                    is_equal,
  output logic [1:0]              status
);
  import rau_pkg::*;

  localparam logic [DW-1:0] LIM = DW'(1) << (WIDTH - 1);

  logic [DW-1:0] lm, ld, rm, rd, pm, pd, t1, t2, g;
  logic          ls, rs, ps, lz, rz;
  logic          cl, cg, ce;
  reg_sel_t      div_dst;

  logic [DW-1:0] va, vb, prod, gcd_g, div_q;
  logic          gcd_done, div_done;
  logic          wr_en;
  reg_sel_t      wr_sel;
  logic [DW-1:0] wr_data;
  logic          s2, pneg, ovf;
  logic [DW-1:0] as_mag;
  logic          as_neg;
  logic          ca, cb;

  function automatic logic [DW-1:0] pick(reg_sel_t s, logic [DW-1:0] a0, logic [DW-1:0] a1,
                                         logic [DW-1:0] a2, logic [DW-1:0] a3,
                                         logic [DW-1:0] a4, logic [DW-1:0] a5,
                                         logic [DW-1:0] a6, logic [DW-1:0] a7);
    logic [DW-1:0] v;
    case (s)
      R_LM:    v = a0;
      R_LD:    v = a1;
      R_RM:    v = a2;
      R_RD:    v = a3;
      R_PM:    v = a4;
      R_PD:    v = a5;
      R_T1:    v = a6;
      R_T2:    v = a7;
      default: v = a0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] mag32(logic [31:0] v);
    return v[31] ? 32'(~v + 32'd1) : v;
  endfunction

  always_comb begin
    va   = pick(ctl.sa, lm, ld, rm, rd, pm, pd, t1, t2);
    vb   = pick(ctl.sb, lm, ld, rm, rd, pm, pd, t1, t2);
    prod = va[31:0] * vb[31:0];
  end

  rau_gcd u_gcd (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.cmd == CMD_GCD),
    .a     (va),
    .b     (vb),
    .done  (gcd_done),
    .g     (gcd_g)
  );

  rau_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.cmd == CMD_DIV),
    .n     (va),
    .d     (g),
    .done  (div_done),
    .q     (div_q)
  );

  // add/sub of m1 (t1) and m2 (rm) in sign-magnitude form
  always_comb begin
    s2 = ctl.sub ? !rs : rs;
    if (ls == s2) begin
      as_neg = ls;
      as_mag = t1 + rm;
    end else if (t1 >= rm) begin
      as_neg = ls;
      as_mag = t1 - rm;
    end else begin
      as_neg = s2;
      as_mag = rm - t1;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_sel  = div_dst;
    wr_data = div_q;
    if (div_done) begin
      wr_en = 1'b1;
    end else if (ctl.cmd == CMD_MUL) begin
      wr_en   = 1'b1;
      wr_sel  = ctl.dst;
      wr_data = prod;
    end
  end

  always_comb begin
    pneg = ps && (pm != '0);
    ovf  = (pneg ? (pm > LIM) : (pm >= LIM)) || (pd >= LIM);
    ca   = ls && (t1 != '0);
    cb   = rs && (t2 != '0);
  end

  always_ff @(posedge clk) begin
    if (ctl.cmd == CMD_LOAD) begin
      lm <= DW'(mag32(left_num));
      ld <= DW'(mag32(left_den));
      rm <= DW'(mag32(right_num));
      rd <= DW'(mag32(right_den));
      ls <= (left_num[31] ^ left_den[31]) && (left_num != '0);
      rs <= (right_num[31] ^ right_den[31]) && (right_num != '0);
      lz <= left_den == '0;
      rz <= right_den == '0;
    end
    if (gcd_done) begin
      g <= gcd_g;
    end
    if (ctl.cmd == CMD_DIV) begin
      div_dst <= ctl.dst;
    end
    if (wr_en) begin
      case (wr_sel)
        R_LM:    lm <= wr_data;
        R_LD:    ld <= wr_data;
        R_RM:    rm <= wr_data;
        R_RD:    rd <= wr_data;
        R_PM:    pm <= wr_data;
        R_PD:    pd <= wr_data;
        R_T1:    t1 <= wr_data;
        R_T2:    t2 <= wr_data;
        default: t2 <= wr_data;
      endcase
    end
    case (ctl.cmd)
      CMD_ADDSUB: begin
        pm <= as_mag;
        ps <= as_neg;
      end
      CMD_SIGN: ps <= ls ^ rs;
      CMD_COPY: begin
        pm <= lm;
        pd <= ld;
        ps <= ls;
      end
      CMD_CMP: begin
        cl <= 1'b0;
        cg <= 1'b0;
        ce <= 1'b0;
        if (ca != cb) begin
          cl <= ca;
          cg <= cb;
        end else if (t1 == t2) begin
          ce <= 1'b1;
        end else if (ca) begin
          cl <= t1 > t2;
          cg <= t1 < t2;
        end else begin
          cl <= t1 < t2;
          cg <= t1 > t2;
        end
      end
      default: ;
    endcase
  end

  // result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.cmd == CMD_FINISH;
    end
    if (ctl.cmd == CMD_FINISH) begin
      result_num <= '0;
      result_den <= '0;
      is_less    <= 1'b0;
      is_greater <= 1'b0;
      is_equal   <= 1'b0;
      status     <= ctl.err;
      if (ctl.err == ST_OK) begin
        if (ctl.cmp) begin
          is_less    <= cl;
          is_greater <= cg;
          is_equal   <= ce;
        end else if (ovf) begin
          status <= ST_OVF;
        end else begin
          result_num <= pneg ? 32'(-pm[31:0]) : pm[31:0];
          result_den <= pd[30:0];
        end
      end
    end
  end

  always_comb begin
    st.gcd_done  = gcd_done;
    st.div_done  = div_done;
    st.lden_zero = lz;
    st.rden_zero = rz;
    st.rm_zero   = rm == '0;
  end

endmodule
`default_nettype wire

// ===== rtl/rau_ctrl.sv =====
// sequencer: steps the datapath through reduce, operate and finish
`default_nettype none
module rau_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [2:0]        op,
  input  wire rau_pkg::dp_stat_t st,
  output rau_pkg::dp_ctl_t       ctl,
  output logic                   busy
);
  import rau_pkg::*;

  ctrl_state_t state, state_next;
  pair_t       pair, pair_next;
  logic [2:0]  op_q, op_q_next;
  logic [1:0]  err, err_next;
  reg_sel_t    px, py;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pair  <= PR_L;
      op_q  <= OP_ADD;
      err   <= ST_OK;
    end else begin
      state <= state_next;
      pair  <= pair_next;
      op_q  <= op_q_next;
      err   <= err_next;
    end
  end

  always_comb begin
    case (pair)
      PR_L: begin
        px = R_LM;
        py = R_LD;
      end
      PR_R: begin
        px = R_RM;
        py = R_RD;
      end
      default: begin
        px = R_PM;
        py = R_PD;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    pair_next  = pair;
    op_q_next  = op_q;
    err_next   = err;
    busy       = state != S_IDLE;
    ctl.cmd    = CMD_NOP;
    ctl.sa     = R_LM;
    ctl.sb     = R_LM;
    ctl.dst    = R_LM;
    ctl.sub    = op_q == OP_SUB;
    ctl.cmp    = op_q == OP_CMP;
    ctl.err    = err;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.cmd    = CMD_LOAD;
          op_q_next  = op;
          err_next   = ST_OK;
          pair_next  = PR_L;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.lden_zero || (op_q inside {[OP_ADD:OP_CMP]} && st.rden_zero)) begin
          err_next   = ST_ZDEN;
          state_next = S_FIN;
        end else begin
          state_next = S_RG;
        end
      end
      S_RG: begin
        ctl.cmd    = CMD_GCD;
        ctl.sa     = px;
        ctl.sb     = py;
        state_next = S_RGW;
      end
      S_RGW: if (st.gcd_done) state_next = S_RX;
      S_RX: begin
        ctl.cmd    = CMD_DIV;
        ctl.sa     = px;
        ctl.dst    = px;
        state_next = S_RXW;
      end
      S_RXW: if (st.div_done) state_next = S_RY;
      S_RY: begin
        ctl.cmd    = CMD_DIV;
        ctl.sa     = py;
        ctl.dst    = py;
        state_next = S_RYW;
      end
      S_RYW: begin
        if (st.div_done) begin
          case (pair)
            PR_L: begin
              if (op_q inside {[OP_ADD:OP_CMP]}) begin
                pair_next  = PR_R;
                state_next = S_RG;
              end else begin
                state_next = S_CP;
              end
            end
            PR_R: begin
              case (op_q)
                OP_ADD, OP_SUB: state_next = S_AG;
                OP_MUL:         state_next = S_M1;
                OP_DIV: begin
                  if (st.rm_zero) begin
                    err_next   = ST_DIVZ;
                    state_next = S_FIN;
                  end else begin
                    state_next = S_M1;
                  end
                end
                OP_CMP:  state_next = S_CM1;
                default: state_next = S_CP;
              endcase
            end
            default: state_next = S_FIN;
          endcase
        end
      end
      // add/sub: bring both to the common denominator
      S_AG: begin
        ctl.cmd    = CMD_GCD;
        ctl.sa     = R_LD;
        ctl.sb     = R_RD;
        state_next = S_AGW;
      end
      S_AGW: if (st.gcd_done) state_next = S_AQ1;
      S_AQ1: begin
        ctl.cmd    = CMD_DIV;
        ctl.sa     = R_RD;
        ctl.dst    = R_T1;
        state_next = S_AQ1W;
      end
      S_AQ1W: if (st.div_done) state_next = S_AQ2;
      S_AQ2: begin
        ctl.cmd    = CMD_DIV;
        ctl.sa     = R_LD;
        ctl.dst    = R_T2;
        state_next = S_AQ2W;
      end
      S_AQ2W: if (st.div_done) state_next = S_AM1;
      S_AM1: begin
        ctl.cmd    = CMD_MUL;
        ctl.sa     = R_LM;
        ctl.sb     = R_T1;
        ctl.dst    = R_T1;
        state_next = S_AM2;
      end
      S_AM2: begin
        ctl.cmd    = CMD_MUL;
        ctl.sa     = R_RM;
        ctl.sb     = R_T2;
        ctl.dst    = R_RM;
        state_next = S_AM3;
      end
      S_AM3: begin
        ctl.cmd    = CMD_MUL;
        ctl.sa     = R_T2;
        ctl.sb     = R_RD;
        ctl.dst    = R_PD;
        state_next = S_AS;
      end
      S_AS: begin
        ctl.cmd    = CMD_ADDSUB;
        pair_next  = PR_P;
        state_next = S_RG;
      end
      S_M1: begin
        ctl.cmd    = CMD_MUL;
        ctl.sa     = R_LM;
        ctl.sb     = (op_q == OP_DIV) ? R_RD : R_RM;
        ctl.dst    = R_PM;
        state_next = S_M2;
      end
      S_M2: begin
        ctl.cmd    = CMD_MUL;
        ctl.sa     = R_LD;
        ctl.sb     = (op_q == OP_DIV) ? R_RM : R_RD;
        ctl.dst    = R_PD;
        state_next = S_MS;
      end
      S_MS: begin
        ctl.cmd    = CMD_SIGN;
        pair_next  = PR_P;
        state_next = S_RG;
      end
      S_CM1: begin
        ctl.cmd    = CMD_MUL;
        ctl.sa     = R_LM;
        ctl.sb     = R_RD;
        ctl.dst    = R_T1;
        state_next = S_CM2;
      end
      S_CM2: begin
        ctl.cmd    = CMD_MUL;
        ctl.sa     = R_RM;
        ctl.sb     = R_LD;
        ctl.dst    = R_T2;
        state_next = S_CC;
      end
      S_CC: begin
        ctl.cmd    = CMD_CMP;
        state_next = S_FIN;
      end
      S_CP: begin
        ctl.cmd    = CMD_COPY;
        state_next = S_FIN;
      end
      S_FIN: begin
        ctl.cmd    = CMD_FINISH;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_end_via_finish: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> $past(state == S_FIN))
    else $error("busy dropped without finishing");

  a_gcd_wait: assert property (@(posedge clk) disable iff (rst)
    st.gcd_done |-> (state == S_RGW || state == S_AGW))
    else $error("gcd completed outside a wait state");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    st.div_done |-> (state == S_RXW || state == S_RYW || state == S_AQ1W ||
                     state == S_AQ2W))
    else $error("divide completed outside a wait state");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// testbench for the rational arithmetic unit core: random and directed operand checks
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import rau_pkg::*;

  typedef struct {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic               lt, gt, eq;
    logic [1:0]         st;
  } rau_res_t;

  class rau_scoreboard;
    rau_res_t pending[$];
    int       errors;

    function logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
      logic [63:0] t;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      return x;
    endfunction

    function void reduce(ref logic neg, ref logic [63:0] mag, ref logic [63:0] den);
      logic [63:0] g;
      g = gcd64(mag, den);
      if (g != 0) begin
        mag = mag / g;
        den = den / g;
      end
      if (mag == 0) neg = 0;
    endfunction

    function logic [63:0] mag32(logic [31:0] v, output logic neg);
      neg = v[31];
      return neg ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
    endfunction

    function logic load_frac(logic [31:0] n, logic [31:0] d, output logic neg,
                             output logic [63:0] mag, output logic [63:0] den);
      logic nn, dn;
      mag = mag32(n, nn);
      den = mag32(d, dn);
      neg = 0;
      if (den == 0) return 0;
      neg = nn != dn;
      reduce(neg, mag, den);
      return 1;
    endfunction

    // compute the expected result for one accepted command
    function void note_command(logic [2:0] op, logic [31:0] ln, logic [31:0] ld,
                               logic [31:0] rn, logic [31:0] rd);
      logic ln_neg, rn_neg, p_neg, s1, s2, lok, rok, ovf;
      logic [63:0] lm, ldn, rm, rdn, pm, pd, g, m1, m2, a, b, lim;
      rau_res_t r;
      r = '{num: 0, den: 0, lt: 0, gt: 0, eq: 0, st: ST_OK};
      lim = 64'd1 << 31;
      lok = load_frac(ln, ld, ln_neg, lm, ldn);
      rok = load_frac(rn, rd, rn_neg, rm, rdn);
      p_neg = 0; pm = 0; pd = 1;
      if (!lok || (op <= OP_CMP && !rok)) begin
        r.st = ST_ZDEN;
      end else if (op == OP_ADD || op == OP_SUB) begin
        g = gcd64(ldn, rdn);
        m1 = lm * (rdn / g);
        m2 = rm * (ldn / g);
        s1 = ln_neg;
        s2 = (op == OP_SUB) ? !rn_neg : rn_neg;
        if (s1 == s2) begin
          p_neg = s1; pm = m1 + m2;
        end else if (m1 >= m2) begin
          p_neg = s1; pm = m1 - m2;
        end else begin
          p_neg = s2; pm = m2 - m1;
        end
        pd = (ldn / g) * rdn;
        reduce(p_neg, pm, pd);
      end else if (op == OP_MUL) begin
        p_neg = ln_neg != rn_neg; pm = lm * rm; pd = ldn * rdn;
        reduce(p_neg, pm, pd);
      end else if (op == OP_DIV) begin
        if (rm == 0) r.st = ST_DIVZ;
        else begin
          p_neg = ln_neg != rn_neg; pm = lm * rdn; pd = ldn * rm;
          reduce(p_neg, pm, pd);
        end
      end else if (op == OP_CMP) begin
        a = lm * rdn;
        b = rm * ldn;
        s1 = (a == 0) ? 0 : ln_neg;
        s2 = (b == 0) ? 0 : rn_neg;
        if (s1 != s2) begin
          r.lt = s1; r.gt = !s1;
        end else if (a == b) r.eq = 1;
        else if (s1) begin
          r.lt = a > b; r.gt = a < b;
        end else begin
          r.gt = a > b; r.lt = a < b;
        end
      end else begin
        p_neg = ln_neg; pm = lm; pd = ldn;
      end
      if (r.st == ST_OK && op != OP_CMP) begin
        ovf = p_neg ? (pm > lim) : (pm >= lim);
        if (ovf || pd >= lim) r.st = ST_OVF;
      end
      if (r.st == ST_OK && op != OP_CMP) begin
        a = p_neg ? (64'd0 - pm) : pm;
        r.num = a[31:0];
        r.den = pd[30:0];
      end
      pending.push_back(r);
    endfunction

    function void check_result(rau_res_t got);
      rau_res_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result num=%0d den=%0d", $time, got.num, got.den);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.num !== want.num) begin
        $display("%0t: result_num expected %0d actual %0d", $time, want.num, got.num);
        errors++;
      end
      if (got.den !== want.den) begin
        $display("%0t: result_den expected %0d actual %0d", $time, want.den, got.den);
        errors++;
      end
      if (got.lt !== want.lt) begin
        $display("%0t: is_less expected %b actual %b", $time, want.lt, got.lt);
        errors++;
      end
      if (got.gt !== want.gt) begin
        $display("%0t: is_greater expected %b actual %b", $time, want.gt, got.gt);
        errors++;
      end
      if (got.eq !== want.eq) begin
        $display("%0t: is_equal expected %b actual %b", $time, want.eq, got.eq);
        errors++;
      end
      if (got.st !== want.st) begin
        $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic [2:0] op = OP_ADD;
  logic signed [31:0] left_num = 0, left_den = 1, right_num = 0, right_den = 1;
  logic busy, done, is_less, is_greater, is_equal;
  logic signed [31:0] result_num;
  logic [30:0] result_den;
  logic [1:0] status;

  rau_scoreboard sb = new();
  int burst_left = 0;

  always #5 clk = ~clk;

  rational_arithmetic_unit_core #(.WIDTH(32)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .left_num(left_num), .left_den(left_den), .right_num(right_num),
    .right_den(right_den), .done(done), .result_num(result_num),
    .result_den(result_den), .is_less(is_less), .is_greater(is_greater),
    .is_equal(is_equal), .status(status)
  );

  always @(posedge clk) begin
    if (!rst && start && !busy) sb.note_command(op, left_num, left_den, right_num, right_den);
    if (!rst && done)
      sb.check_result('{num: result_num, den: result_den, lt: is_less,
                        gt: is_greater, eq: is_equal, st: status});
  end

  // issue one beat, with a random gap between bursts
  task automatic send_cmd(logic [2:0] o, logic [31:0] ln, logic [31:0] ld,
                          logic [31:0] rn, logic [31:0] rd);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    op = o; left_num = ln; left_den = ld; right_num = rn; right_den = rd;
    start = 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start = 0;
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 12);
      1: return -$urandom_range(0, 12);
      2: return $urandom_range(0, 2000) - 1000;
      3: return $urandom;
      4: return $urandom >> $urandom_range(0, 31);
      default: return (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
    endcase
  endfunction

  function automatic logic [31:0] rand_den();
    // occasionally zero to exercise the zero-denominator path
    if ($urandom_range(0, 30) == 0) return 0;
    return rand_val();
  endfunction

  initial begin
    logic [31:0] mn, mx;
    mn = 32'h8000_0000;
    mx = 32'h7fff_ffff;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;
    send_cmd(OP_ADD, 1, 2, 1, 3);
    send_cmd(OP_SUB, 1, 2, 1, 2);
    send_cmd(OP_MUL, -3, 4, 2, -9);
    send_cmd(OP_DIV, 5, 7, 0, 3);
    send_cmd(OP_DIV, 2, 3, -4, 9);
    send_cmd(OP_CMP, 1, 3, 2, 6);
    send_cmd(OP_CMP, -1, 3, 1, 3);
    send_cmd(OP_CMP, 0, -5, 0, 7);
    send_cmd(OP_NORM, 6, -8, 0, 0);
    send_cmd(OP_NORM, 0, -8, 1, 1);
    send_cmd(OP_ADD, 1, 0, 1, 1);
    send_cmd(OP_DIV, 1, 1, 0, 0);
    send_cmd(OP_NORM, mn, 1, 0, 0);
    send_cmd(OP_NORM, mn, -1, 0, 0);
    send_cmd(OP_NORM, 1, mn, 0, 0);
    send_cmd(OP_MUL, mx, 1, mx, 1);
    send_cmd(OP_ADD, mx, 1, 1, 1);
    send_cmd(OP_SUB, mn, 1, 1, 1);
    send_cmd(OP_DIV, mn, mn, mn, mn);
    send_cmd(OP_CMP, mn, 1, mx, 1);
    send_cmd(3'd6, -4, 6, 0, 0);
    send_cmd(3'd7, mx, mn, 1, 0);
    send_cmd(OP_MUL, mx, mn, mn, mx);
    send_cmd(OP_CMP, mn, mx, mx, mn);
    repeat (750)
      send_cmd(3'($urandom_range(0, 7)), rand_val(), rand_den(), rand_val(), rand_den());
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    #50ms;
    $display("tb_top NOT OK");
    $finish;
  end
endmodule
`default_nettype wire
